// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types and helpers for the point-in-polygon test
// Coordinate widths, edge job word and the edge classification function.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // One edge, already classified. Crossing iff ok and a*dx < pxi*d.
  typedef struct packed {
    logic  ok;
    diff_t a;
    diff_t dx;
    diff_t pxi;
    diff_t d;
  } edge_t;

  // One word per accepted vertex: the edge to the prior vertex and the
  // closing edge back to the first vertex.
  typedef struct packed {
    edge_t link;
    edge_t close;
    logic  start;
    logic  last;
  } job_t;

  typedef struct packed {
    logic  ok;
    prod_t lhs;
    prod_t rhs;
  } prod_pair_t;

  function automatic edge_t edge_prep(input coord_t px, input coord_t py,
                                      input coord_t xi, input coord_t yi,
                                      input coord_t xj, input coord_t yj,
                                      input logic use_it);
    edge_t e;
    diff_t d;
    diff_t a;
    d = diff_t'(yj) - diff_t'(yi);
    a = diff_t'(py) - diff_t'(yi);
    // half-open straddle in y, and at least one end at or left of the point
    e.ok  = use_it && ((yi < py && yj >= py) || (yj < py && yi >= py)) &&
            (xi <= px || xj <= px);
    // keep the divisor positive so the compare direction holds
    e.a   = d[DIFF_W-1] ? -a : a;
    e.d   = d[DIFF_W-1] ? -d : d;
    e.dx  = diff_t'(xj) - diff_t'(xi);
    e.pxi = diff_t'(px) - diff_t'(xi);
    return e;
  endfunction

endpackage

// ===== rtl/point_in_polygon_test.sv =====
// Path: after the last vertex is accepted the result passes through the queue,
// the product register and the output register.
// Throughput: one vertex per cycle while the output is not stalled; each vertex uses four parallel multipliers.
// Reset: synchronous active-high rst empties the queue, clears parity and
// arms the next vertex as the first of a new polygon.
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd point-in-polygon test
// Streams polygon vertices and reports inside/outside on the closing vertex.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t query_x,
  input  coord_t query_y,
  input  coord_t vertex_x,
  input  coord_t vertex_y,
  input  logic   last_vertex,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   inside_res
);

  logic q_ready;
  logic q_push;
  job_t q_in_job;
  logic q_valid;
  logic q_pop;
  job_t q_out_job;

  pip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .query_x     (query_x),
    .query_y     (query_y),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_job       (q_in_job)
  );

  pip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_job   (q_in_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_job    (q_out_job)
  );

  pip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_job      (q_out_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res)
  );

endmodule

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front: vertex intake
// Tracks the query point and first/prior vertex, turns each vertex into a job.
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t query_x,
  input  coord_t query_y,
  input  coord_t vertex_x,
  input  coord_t vertex_y,
  input  logic   last_vertex,
  input  logic   q_ready,
  output logic   q_push,
  output job_t   q_job
);

  coord_t held_point_x;
  coord_t held_point_y;
  coord_t first_corner_x;
  coord_t first_corner_y;
  coord_t prior_corner_x;
  coord_t prior_corner_y;
  logic   awaiting_first;

  coord_t px;
  coord_t py;
  coord_t fx;
  coord_t fy;
  logic   accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept;

  // on a polygon's first vertex the query and the vertex itself stand in
  assign px = awaiting_first ? query_x  : held_point_x;
  assign py = awaiting_first ? query_y  : held_point_y;
  assign fx = awaiting_first ? vertex_x : first_corner_x;
  assign fy = awaiting_first ? vertex_y : first_corner_y;

  always_comb begin
    q_job.link  = edge_prep(px, py, vertex_x, vertex_y, prior_corner_x, prior_corner_y,
                            !awaiting_first);
    q_job.close = edge_prep(px, py, fx, fy, vertex_x, vertex_y, last_vertex);
    q_job.start = awaiting_first;
    q_job.last  = last_vertex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_point_x   <= '0;
      held_point_y   <= '0;
      first_corner_x <= '0;
      first_corner_y <= '0;
      prior_corner_x <= '0;
      prior_corner_y <= '0;
      awaiting_first <= 1'b1;
    end else if (accept) begin
      held_point_x   <= px;
      held_point_y   <= py;
      first_corner_x <= fx;
      first_corner_y <= fy;
      prior_corner_x <= vertex_x;
      prior_corner_y <= vertex_y;
      awaiting_first <= last_vertex;
    end
  end

endmodule

// ===== rtl/pip_queue.sv =====
// ----------------------------------------------------------------------------
// pip_queue: job queue
// Small register FIFO between intake and edge evaluation.
// ----------------------------------------------------------------------------
module pip_queue import pip_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ===== rtl/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back: edge evaluation
// Multiplies, compares, folds crossings into parity and drives the result.
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  job_t q_job,
  output logic out_valid,
  input  logic out_ready,
  output logic inside_res
);

  logic       advance;
  logic       s1_valid;
  prod_pair_t s1_link;
  prod_pair_t s1_close;
  logic       s1_start;
  logic       s1_last;
  logic       parity;
  logic       parity_next;
  logic       link_hit;
  logic       close_hit;

  // stall the whole back end only while a result waits at the output
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  assign link_hit    = s1_link.ok  && (s1_link.lhs  < s1_link.rhs);
  assign close_hit   = s1_close.ok && (s1_close.lhs < s1_close.rhs);
  assign parity_next = (s1_start ? 1'b0 : parity) ^ link_hit ^ close_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      parity    <= 1'b0;
    end else if (advance) begin
      s1_valid  <= q_valid;
      out_valid <= s1_valid && s1_last;
      if (s1_valid) parity <= parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_link.ok   <= q_job.link.ok;
      s1_link.lhs  <= prod_t'(q_job.link.a) * prod_t'(q_job.link.dx);
      s1_link.rhs  <= prod_t'(q_job.link.pxi) * prod_t'(q_job.link.d);
      s1_close.ok  <= q_job.close.ok;
      s1_close.lhs <= prod_t'(q_job.close.a) * prod_t'(q_job.close.dx);
      s1_close.rhs <= prod_t'(q_job.close.pxi) * prod_t'(q_job.close.d);
      s1_start     <= q_job.start;
      s1_last      <= q_job.last;
    end
    if (advance && s1_valid && s1_last) inside_res <= parity_next;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the even-odd point-in-polygon test
// Streams polygons one vertex per word and tracks the crossing parity of each
// edge in a local predictor. Every inside/outside result is checked in order
// against the predicted flag. Both sides of the handshake idle at random while
// pacing is on.
module tb_top;
  import pip_pkg::*;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t query_x = '0;
  coord_t query_y = '0;
  coord_t vertex_x = '0;
  coord_t vertex_y = '0;
  logic   last_vertex = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   inside_res;

  point_in_polygon_test DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .query_x(query_x), .query_y(query_y),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_ready(out_ready), .inside_res(inside_res)
  );

  always #1 clk = ~clk;

  // polygon tracking state, mirrors what the block latches
  coord_t pin_x, pin_y;
  coord_t first_x, first_y;
  coord_t prior_x, prior_y;
  bit     parity;
  bit     new_polygon = 1'b1;

  bit     inside_expect[$];
  coord_t poly_x[$];
  coord_t poly_y[$];
  bit     pace_on = 1'b0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     vertices_sent = 0;
  int     stall_left = 0;

  // exact test for one edge: half-open y straddle, x prefilter, then the
  // crossing x compared against the point by cross-multiplication
  function automatic bit edge_crossing(coord_t xi, coord_t yi, coord_t xj, coord_t yj);
    longint px, py, d, a;
    px = longint'(pin_x);
    py = longint'(pin_y);
    if (!((yi < pin_y && yj >= pin_y) || (yj < pin_y && yi >= pin_y)))
      return 1'b0;
    if (!(xi <= pin_x || xj <= pin_x))
      return 1'b0;
    d = longint'(yj) - longint'(yi);
    a = py - longint'(yi);
    if (d < 0) begin
      d = -d;
      a = -a;
    end
    return (a * (longint'(xj) - longint'(xi))) < ((px - longint'(xi)) * d);
  endfunction

  function automatic void track_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
                                       bit last);
    if (new_polygon) begin
      pin_x = qx;
      pin_y = qy;
      first_x = vx;
      first_y = vy;
      parity = 1'b0;
      new_polygon = 1'b0;
    end else begin
      parity ^= edge_crossing(vx, vy, prior_x, prior_y);
    end
    prior_x = vx;
    prior_y = vy;
    if (last) begin
      parity ^= edge_crossing(first_x, first_y, prior_x, prior_y);
      inside_expect = {inside_expect, parity};
      new_polygon = 1'b1;
    end
  endfunction

  task automatic flag_mismatch(string what, bit want, logic got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d: %s, expected %0b got %0b",
               results_seen, what, want, got);
  endtask

  // called at a rising edge; hold valid across back-to-back words
  task automatic send_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, bit last);
    if (pace_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    query_x     <= qx;
    query_y     <= qy;
    vertex_x    <= vx;
    vertex_y    <= vy;
    last_vertex <= last;
    do @(posedge clk); while (!in_ready);
    track_vertex(qx, qy, vx, vy, last);
    vertices_sent++;
  endtask

  // query fields on later vertices carry noise the block must ignore
  task automatic send_polygon(coord_t qx, coord_t qy);
    for (int i = 0; i < poly_x.size(); i++) begin
      if (i == 0)
        send_vertex(qx, qy, poly_x[i], poly_y[i], poly_x.size() == 1);
      else
        send_vertex(coord_t'($urandom), coord_t'($urandom), poly_x[i], poly_y[i],
                    i == poly_x.size() - 1);
    end
  endtask

  function automatic coord_t pick_near(coord_t center);
    longint v;
    case ($urandom_range(0, 9))
      0, 1:    v = longint'(coord_t'($urandom));
      2, 3, 4: v = longint'(center) + longint'($urandom_range(0, 128)) - 64;
      5, 6:    v = longint'(center) + 256 * longint'($urandom_range(0, 8)) - 1024;
      7:       v = longint'(center);
      default: v = longint'(center) + longint'($urandom_range(0, 131072)) - 65536;
    endcase
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return coord_t'(v);
  endfunction

  task automatic test_degenerate_polygons();
    // single vertex at the corners of the range, then a two vertex polygon
    poly_x = '{-24'sd8388608};
    poly_y = '{24'sd8388607};
    send_polygon(24'sd0, 24'sd0);
    poly_x = '{24'sd8388607};
    poly_y = '{-24'sd8388608};
    send_polygon(24'sd8388607, -24'sd8388608);
    poly_x = '{-24'sd512, 24'sd512};
    poly_y = '{-24'sd512, 24'sd512};
    send_polygon(24'sd0, 24'sd0);
  endtask

  task automatic test_simple_shapes();
    // square of side 512: point inside, then outside to the right
    poly_x = '{-24'sd256, 24'sd256, 24'sd256, -24'sd256};
    poly_y = '{-24'sd256, -24'sd256, 24'sd256, 24'sd256};
    send_polygon(24'sd0, 24'sd0);
    send_polygon(24'sd512, 24'sd0);
    // triangle with a horizontal edge level with the point
    poly_x = '{-24'sd512, 24'sd512, 24'sd0};
    poly_y = '{24'sd0, 24'sd0, 24'sd768};
    send_polygon(24'sd0, 24'sd0);
    // square spanning the whole coordinate range, point near the centre, then at a corner
    poly_x = '{-24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608};
    poly_y = '{-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607};
    send_polygon(24'sd1, -24'sd1);
    send_polygon(-24'sd8388608, 24'sd8388607);
  endtask

  task automatic test_random_polygons(int target);
    coord_t qx, qy;
    int     n;
    int     stop_at;
    bit     wide;
    stop_at = vertices_sent + target;
    while (vertices_sent < stop_at) begin
      qx = (($urandom_range(0, 3)) == 0) ? coord_t'($urandom)
                                          : coord_t'(int'($urandom_range(0, 4096)) - 2048);
      qy = (($urandom_range(0, 3)) == 0) ? coord_t'($urandom)
                                          : coord_t'(int'($urandom_range(0, 4096)) - 2048);
      case ($urandom_range(0, 11))
        0:       n = 1;
        1:       n = 2;
        default: n = $urandom_range(3, 8);
      endcase
      wide = ($urandom_range(0, 7) == 0);
      poly_x.delete();
      poly_y.delete();
      for (int i = 0; i < n; i++) begin
        poly_x = {poly_x, (wide ? coord_t'($urandom) : pick_near(qx))};
        poly_y = {poly_y, (wide ? coord_t'($urandom) : pick_near(qy))};
      end
      send_polygon(qx, qy);
    end
  endtask

  // receiver stalls in bursts while pacing is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (pace_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    bit want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (inside_expect.size() == 0) begin
        flag_mismatch("result with nothing pending", 1'b0, inside_res);
      end else begin
        want = inside_expect.pop_front();
        if (inside_res !== want)
          flag_mismatch("inside_res", want, inside_res);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate_polygons();
    test_simple_shapes();
    pace_on = 1'b1;
    test_random_polygons(1400);
    pace_on = 1'b0;
    test_random_polygons(300);
    in_valid <= 1'b0;
    while (inside_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && inside_expect.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
